FILE: src/lsswa_pkg.sv
// Shared types, constants and palette functions of the LED strip scanner and wipe animator.
package lsswa_pkg;

   localparam int unsigned LenWidth   = 7;
   localparam int unsigned PixWidth   = 24;
   localparam int unsigned IndexWidth = 6;
   localparam int unsigned QueueDepth = 2;

   localparam logic [LenWidth-1:0] LenReset       = 7'd8;
   localparam logic [PixWidth-1:0] ScanColorReset = 24'h001F00;
   localparam logic [PixWidth-1:0] WipeColorReset = 24'h1F0700;
   localparam logic [PixWidth-1:0] HalfMask       = 24'h7F7F7F;

   typedef logic [PixWidth-1:0] rgb_type;
   typedef logic [2:0] palette_step_type;

   localparam palette_step_type PaletteFirst = 3'd0;
   localparam palette_step_type PaletteLast  = 3'd5;

   // One frame tick as handed from the front end to the pixel sequencer.
   typedef struct packed {
      logic                  scan;
      logic [LenWidth-1:0]   len;
      logic [LenWidth-1:0]   pos;
      logic                  has_mirror;
      logic [LenWidth-1:0]   mirror;
      rgb_type               color;
      logic [IndexWidth-1:0] wipe_idx;
   } cmd_type;

   // Six-entry palette; the two unused step codes behave as the first entry.
   function automatic rgb_type palette_color(input palette_step_type step);
      rgb_type c;
      case (step)
         3'd1:    c = 24'h1F1F00;
         3'd2:    c = 24'h001F00;
         3'd3:    c = 24'h001F1F;
         3'd4:    c = 24'h1F1F1F;
         3'd5:    c = 24'h1F001F;
         default: c = 24'h1F0000;
      endcase
      return c;
   endfunction

   function automatic palette_step_type palette_next(input palette_step_type step);
      palette_step_type n;
      if (step == PaletteLast) begin
         n = PaletteFirst;
      end else if (step > PaletteLast) begin
         n = PaletteFirst + 3'd1;
      end else begin
         n = step + 3'd1;
      end
      return n;
   endfunction

endpackage

FILE: src/lsswa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module lsswa_ram #(
   parameter int unsigned Width = 24,
   parameter int unsigned Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/lsswa_front.sv
// Front end: accepts frame ticks, keeps scanner, wipe and palette state, and builds commands.
module lsswa_front import lsswa_pkg::*; #(
   parameter int unsigned MAX_LEDS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [LenWidth-1:0] strip_length,
   input  logic                push,
   output logic                full,
   input  logic                scanner_mode,
   input  logic                refresh_accepted,
   output logic                cmd_push,
   output cmd_type             cmd_data,
   input  logic                cmd_full
);

   localparam int unsigned IW = $clog2(MAX_LEDS);
   localparam logic [LenWidth-1:0] MaxLen = LenWidth'(MAX_LEDS);

   logic [LenWidth-1:0] scan_position_ff, scan_position_in;
   logic                scan_reverse_ff, scan_reverse_in;
   rgb_type             scan_color_ff, scan_color_in;
   logic [IW-1:0]       wipe_position_ff, wipe_position_in;
   rgb_type             wipe_color_ff, wipe_color_in;
   palette_step_type    palette_step_ff, palette_step_in;

   logic                accept;
   logic [LenWidth-1:0] len;
   logic [LenWidth-1:0] len_m1;
   logic [LenWidth-1:0] total;
   logic                has_mirror;
   logic [LenWidth-1:0] step_pos;
   logic [IW:0]         wipe_next;

   assign accept   = push & ~cmd_full;
   assign full     = cmd_full;
   assign cmd_push = accept;

   always_comb begin
      if (strip_length == '0) begin
         len = LenWidth'(1);
      end else if (strip_length > MaxLen) begin
         len = MaxLen;
      end else begin
         len = strip_length;
      end
      len_m1     = len - LenWidth'(1);
      total      = {len_m1[LenWidth-2:0], 1'b0};
      has_mirror = scan_position_ff <= total;
      step_pos   = scan_reverse_ff ? scan_position_ff - LenWidth'(1)
                                   : scan_position_ff + LenWidth'(1);
      wipe_next  = {1'b0, wipe_position_ff} + (IW+1)'(1);
   end

   always_comb begin
      cmd_data.scan       = scanner_mode;
      cmd_data.len        = scanner_mode ? len : LenWidth'(1);
      cmd_data.pos        = scan_position_ff;
      cmd_data.has_mirror = has_mirror;
      cmd_data.mirror     = total - scan_position_ff;
      cmd_data.color      = scanner_mode ? scan_color_ff : wipe_color_ff;
      cmd_data.wipe_idx   = IndexWidth'(wipe_position_ff);
   end

   always_comb begin
      scan_position_in = scan_position_ff;
      scan_reverse_in  = scan_reverse_ff;
      scan_color_in    = scan_color_ff;
      wipe_position_in = wipe_position_ff;
      wipe_color_in    = wipe_color_ff;
      palette_step_in  = palette_step_ff;
      if (accept) begin
         if (scanner_mode) begin
            if (refresh_accepted) begin
               scan_position_in = step_pos;
               if (step_pos >= len) begin
                  scan_reverse_in = 1'b1;
               end else if (step_pos == '0) begin
                  scan_reverse_in = 1'b0;
                  scan_color_in   = palette_color(palette_step_ff);
                  palette_step_in = palette_next(palette_step_ff);
               end
            end
         end else begin
            // The wipe moves on whether or not the refresh went through.
            if (LenWidth'(wipe_next) >= len) begin
               wipe_position_in = '0;
               wipe_color_in    = palette_color(palette_step_ff);
               palette_step_in  = palette_next(palette_step_ff);
            end else begin
               wipe_position_in = wipe_next[IW-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_position_ff <= '0;
         scan_reverse_ff  <= 1'b0;
         scan_color_ff    <= ScanColorReset;
         wipe_position_ff <= '0;
         wipe_color_ff    <= WipeColorReset;
         palette_step_ff  <= PaletteFirst;
      end else begin
         scan_position_ff <= scan_position_in;
         scan_reverse_ff  <= scan_reverse_in;
         scan_color_ff    <= scan_color_in;
         wipe_position_ff <= wipe_position_in;
         wipe_color_ff    <= wipe_color_in;
         palette_step_ff  <= palette_step_in;
      end
   end

   // The scanner only turns around above zero, so it never sits at zero moving down.
   assert property (@(posedge clock) disable iff (reset)
      !(scan_reverse_ff && scan_position_ff == '0))
      else $error("scanner reversed at position zero");

   assert property (@(posedge clock) disable iff (reset)
      palette_step_ff <= PaletteLast)
      else $error("palette step left the palette");

endmodule

FILE: src/lsswa_cmd_fifo.sv
// Short command queue between the front end and the pixel sequencer.
module lsswa_cmd_fifo import lsswa_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   output logic    valid,
   input  logic    pop,
   output cmd_type head
);

   localparam int unsigned PtrWidth   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int unsigned CountWidth = $clog2(QueueDepth + 1);
   localparam logic [PtrWidth-1:0]   PtrLast   = PtrWidth'(QueueDepth - 1);
   localparam logic [CountWidth-1:0] CountFull = CountWidth'(QueueDepth);

   cmd_type                 entry_ff [QueueDepth];
   logic [PtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]   count_ff, count_in;
   logic                    do_push;
   logic                    do_pop;

   assign full    = count_ff == CountFull;
   assign valid   = count_ff != '0;
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + PtrWidth'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + PtrWidth'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CountWidth'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountFull)
      else $error("command queue count above its depth");

endmodule

FILE: src/lsswa_back.sv
// Pixel sequencer: walks each command over the pixel buffer and emits pixel writes.
module lsswa_back import lsswa_pkg::*; #(
   parameter int unsigned MAX_LEDS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cmd_valid,
   input  cmd_type                     cmd_data,
   output logic                        cmd_pop,
   output logic                        out_valid,
   input  logic                        out_pop,
   output logic [$clog2(MAX_LEDS)-1:0] out_index,
   output rgb_type                     out_color,
   output logic                        out_last
);

   localparam int unsigned IW = $clog2(MAX_LEDS);

   // Issue stage.
   logic [LenWidth-1:0] cnt_ff, cnt_in;
   logic                a_last;
   logic [IW-1:0]       a_idx;
   logic                a_use_color;
   logic                a_issue;

   // Read stage, aligned with the registered RAM output.
   logic                b_valid_ff, b_valid_in;
   logic [IW-1:0]       b_idx_ff;
   rgb_type             b_color_ff;
   logic                b_use_color_ff;
   logic                b_last_ff;
   logic                b_hit_ff;
   logic                b_byp_ff;
   rgb_type             b_byp_data_ff;
   rgb_type             b_prev;
   rgb_type             b_pixel;
   logic                b_fire;
   logic                b_advance;

   // Output register.
   logic                o_valid_ff, o_valid_in;
   logic [IW-1:0]       o_idx_ff;
   rgb_type             o_color_ff;
   logic                o_last_ff;
   logic                o_ready;

   logic [MAX_LEDS-1:0] written_ff;
   rgb_type             ram_q;

   assign a_last      = (cnt_ff + LenWidth'(1)) == cmd_data.len;
   assign a_idx       = cmd_data.scan ? cnt_ff[IW-1:0] : cmd_data.wipe_idx[IW-1:0];
   assign a_use_color = ~cmd_data.scan | (cnt_ff == cmd_data.pos)
                      | (cmd_data.has_mirror & (cnt_ff == cmd_data.mirror));

   assign o_ready   = ~o_valid_ff | out_pop;
   assign b_fire    = b_valid_ff & o_ready;
   assign b_advance = ~b_valid_ff | b_fire;
   assign a_issue   = cmd_valid & b_advance;
   assign cmd_pop   = a_issue & a_last;

   // Entries never written read as dark; a write in the same cycle is forwarded.
   assign b_prev  = b_byp_ff ? b_byp_data_ff : (b_hit_ff ? ram_q : '0);
   assign b_pixel = b_use_color_ff ? b_color_ff : ((b_prev >> 1) & HalfMask);

   always_comb begin
      cnt_in = cnt_ff;
      if (a_issue) begin
         cnt_in = a_last ? '0 : cnt_ff + LenWidth'(1);
      end
      b_valid_in = b_valid_ff;
      if (a_issue) begin
         b_valid_in = 1'b1;
      end else if (b_fire) begin
         b_valid_in = 1'b0;
      end
      o_valid_in = o_valid_ff;
      if (b_fire) begin
         o_valid_in = 1'b1;
      end else if (out_pop) begin
         o_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         b_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
         written_ff <= '0;
      end else begin
         cnt_ff     <= cnt_in;
         b_valid_ff <= b_valid_in;
         o_valid_ff <= o_valid_in;
         if (b_fire) begin
            written_ff[b_idx_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_issue) begin
         b_idx_ff       <= a_idx;
         b_color_ff     <= cmd_data.color;
         b_use_color_ff <= a_use_color;
         b_last_ff      <= a_last;
         b_hit_ff       <= written_ff[a_idx];
         b_byp_ff       <= b_fire & (b_idx_ff == a_idx);
         b_byp_data_ff  <= b_pixel;
      end
      if (b_fire) begin
         o_idx_ff   <= b_idx_ff;
         o_color_ff <= b_pixel;
         o_last_ff  <= b_last_ff;
      end
   end

   lsswa_ram #(
      .Width (PixWidth),
      .Depth (MAX_LEDS)
   ) u_pixel_ram (
      .clock   (clock),
      .wr_en   (b_fire),
      .wr_addr (b_idx_ff),
      .wr_data (b_pixel),
      .rd_en   (a_issue),
      .rd_addr (a_idx),
      .rd_data (ram_q)
   );

   assign out_valid = o_valid_ff;
   assign out_index = o_idx_ff;
   assign out_color = o_color_ff;
   assign out_last  = o_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> (32'(b_idx_ff) < MAX_LEDS))
      else $error("pixel index beyond the buffer");

   // A command leaves the queue only on the beat that ends it.
   assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> (cnt_ff == '0))
      else $error("pixel counter not rewound after the last beat");

endmodule

FILE: src/led_strip_scanner_wipe_animator.sv
// Top level of the LED strip scanner and color wipe animator.
//
// Input channel: one transaction per frame tick, taken when push is high and full is
// low, carrying req_scanner_mode and req_refresh_accepted. Result channel: one
// transaction per pixel write, offered while empty is low and taken when pop is high;
// rsp_last_of_tick marks the final write of a tick. csr_write_en loads strip_length
// from csr_write_data at that clock edge; change it only while the block is idle.
//
// A scanner tick produces one write per LED of the strip (1 to MAX_LEDS), in index
// order; a wipe tick produces one write. The first write of a tick passes through the
// command queue, the RAM read stage and the output register on its way to the result
// ports. Ticks are queued two deep between the front end and the sequencer; the tick
// being walked keeps its slot until its last write issues, so one further tick is
// accepted while the sequencer works.
//
// Reset clears all pixels to dark, sets strip_length to 8, and restores the scanner,
// wipe and palette state; no clearing sweep is needed because per-LED written flags
// make untouched pixels read as dark. When the receiver stops popping, the output
// register holds, the sequencer stalls, the queue fills and full rises.
module led_strip_scanner_wipe_animator import lsswa_pkg::*; #(
   parameter int unsigned MAX_LEDS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_en,
   input  logic [LenWidth-1:0] csr_write_data,
   input  logic                push,
   output logic                full,
   input  logic                req_scanner_mode,
   input  logic                req_refresh_accepted,
   output logic                empty,
   input  logic                pop,
   output logic [5:0]          rsp_led_index,
   output logic [7:0]          rsp_red_level,
   output logic [7:0]          rsp_green_level,
   output logic [7:0]          rsp_blue_level,
   output logic                rsp_last_of_tick
);

   localparam int unsigned IW = $clog2(MAX_LEDS);

   logic [LenWidth-1:0] strip_length_ff, strip_length_in;

   logic    cmd_push;
   cmd_type cmd_push_data;
   logic    cmd_full;
   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd_head;

   logic          out_valid;
   logic          out_pop;
   logic [IW-1:0] out_index;
   rgb_type       out_color;
   logic          out_last;

   // Strip length register; unchecked user rule: written only while no tick is in flight.
   assign strip_length_in = csr_write_en ? csr_write_data : strip_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         strip_length_ff <= LenReset;
      end else begin
         strip_length_ff <= strip_length_in;
      end
   end

   lsswa_front #(
      .MAX_LEDS (MAX_LEDS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .strip_length     (strip_length_ff),
      .push             (push),
      .full             (full),
      .scanner_mode     (req_scanner_mode),
      .refresh_accepted (req_refresh_accepted),
      .cmd_push         (cmd_push),
      .cmd_data         (cmd_push_data),
      .cmd_full         (cmd_full)
   );

   lsswa_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_push_data),
      .full      (cmd_full),
      .valid     (cmd_valid),
      .pop       (cmd_pop),
      .head      (cmd_head)
   );

   lsswa_back #(
      .MAX_LEDS (MAX_LEDS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_head),
      .cmd_pop   (cmd_pop),
      .out_valid (out_valid),
      .out_pop   (out_pop),
      .out_index (out_index),
      .out_color (out_color),
      .out_last  (out_last)
   );

   // The result side is a plain queue view of the sequencer's output register.
   assign empty            = ~out_valid;
   assign out_pop          = pop & out_valid;
   assign rsp_led_index    = 6'(out_index);
   assign rsp_red_level    = out_color[23:16];
   assign rsp_green_level  = out_color[15:8];
   assign rsp_blue_level   = out_color[7:0];
   assign rsp_last_of_tick = out_last;

endmodule

FILE: bench/tb_top.sv
// Self-checking testbench for the LED strip scanner and color wipe animator.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lsswa_pkg::*;

   localparam int unsigned LED_SLOTS    = 64;
   localparam int unsigned SETTLE_WAIT  = 8;     // post-drain pause, a bit over the latency
   localparam int unsigned STALL_LIMIT  = 1000;  // cycles without any transaction
   localparam int unsigned PHASE_COUNT  = 3;
   localparam int unsigned SEGMENTS     = 4;     // strip length changes per phase
   localparam int unsigned SEGMENT_TICKS = 25;

   localparam logic MODE_WIPE = 1'b0;
   localparam logic MODE_SCAN = 1'b1;

   localparam rgb_type PALETTE [6] = '{24'h1F0000, 24'h1F1F00, 24'h001F00,
                                       24'h001F1F, 24'h1F1F1F, 24'h1F001F};

   typedef enum logic {ROW_TICK, ROW_SET_LEN} row_kind_type;

   // One pixel write as it leaves the block.
   typedef struct packed {
      logic [5:0] led;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last;
   } led_write_type;

   // One line of the directed stimulus. A tick row may carry its single expected
   // pixel write typed in; all other tick rows are checked against the frame predictor.
   typedef struct {
      row_kind_type        kind;
      logic                scan;
      logic                refresh;
      logic [LenWidth-1:0] len_value;
      bit                  typed;
      logic [5:0]          typed_led;
      rgb_type             typed_rgb;
      logic                typed_last;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_write_en = 1'b0;
   logic [LenWidth-1:0] csr_write_data = '0;
   logic                push = 1'b0;
   logic                full;
   logic                req_scanner_mode = 1'b0;
   logic                req_refresh_accepted = 1'b0;
   logic                empty;
   logic                pop = 1'b0;
   logic [5:0]          rsp_led_index;
   logic [7:0]          rsp_red_level;
   logic [7:0]          rsp_green_level;
   logic [7:0]          rsp_blue_level;
   logic                rsp_last_of_tick;

   // Shadow copy of the animator state, advanced once per accepted tick.
   rgb_type             shadow_pixels [LED_SLOTS];
   logic [LenWidth-1:0] strip_len;
   logic [6:0]          scan_pos;
   logic                scan_rev;
   rgb_type             scan_rgb;
   logic [5:0]          wipe_pos;
   rgb_type             wipe_rgb;
   palette_step_type    pal_step;

   led_write_type writes_due [$];
   int unsigned  fail_count = 0;
   int unsigned  send_idle_pct = 10;
   int unsigned  recv_idle_pct = 60;
   int unsigned  quiet_cycles = 0;

   stim_row_type directed_rows [$] = '{
      // Right after reset: the wipe starts at LED 0 with its reset color, and a
      // refused refresh still moves the wipe on.
      '{ROW_TICK, MODE_WIPE, 1'b1, 7'd0, 1'b1, 6'd0, WipeColorReset, 1'b1},
      '{ROW_TICK, MODE_WIPE, 1'b0, 7'd0, 1'b1, 6'd1, WipeColorReset, 1'b1},
      '{ROW_TICK, MODE_WIPE, 1'b1, 7'd0, 1'b0, 6'd0, '0, 1'b0},
      '{ROW_TICK, MODE_WIPE, 1'b1, 7'd0, 1'b0, 6'd0, '0, 1'b0},
      // Walk the scanner up the default eight LED strip, one refused refresh between.
      '{ROW_TICK, MODE_SCAN, 1'b1, 7'd0, 1'b0, 6'd0, '0, 1'b0},
      '{ROW_TICK, MODE_SCAN, 1'b1, 7'd0, 1'b0, 6'd0, '0, 1'b0},
      '{ROW_TICK, MODE_SCAN, 1'b0, 7'd0, 1'b0, 6'd0, '0, 1'b0},
      '{ROW_TICK, MODE_SCAN, 1'b1, 7'd0, 1'b0, 6'd0, '0, 1'b0},
      '{ROW_TICK, MODE_SCAN, 1'b1, 7'd0, 1'b0, 6'd0, '0, 1'b0},
      '{ROW_TICK, MODE_SCAN, 1'b1, 7'd0, 1'b0, 6'd0, '0, 1'b0},
      // Shorten the strip under both positions: the scanner sits past the end with
      // no mirror LED, and the wipe writes beyond the strip and wraps at once.
      '{ROW_SET_LEN, MODE_WIPE, 1'b0, 7'd3, 1'b0, 6'd0, '0, 1'b0},
      '{ROW_TICK, MODE_SCAN, 1'b1, 7'd0, 1'b0, 6'd0, '0, 1'b0},
      '{ROW_TICK, MODE_SCAN, 1'b1, 7'd0, 1'b0, 6'd0, '0, 1'b0},
      '{ROW_TICK, MODE_SCAN, 1'b1, 7'd0, 1'b0, 6'd0, '0, 1'b0},
      '{ROW_TICK, MODE_WIPE, 1'b0, 7'd0, 1'b0, 6'd0, '0, 1'b0},
      // A zero length behaves as a single LED.
      '{ROW_SET_LEN, MODE_WIPE, 1'b0, 7'd0, 1'b0, 6'd0, '0, 1'b0},
      '{ROW_TICK, MODE_SCAN, 1'b1, 7'd0, 1'b0, 6'd0, '0, 1'b0},
      '{ROW_TICK, MODE_WIPE, 1'b1, 7'd0, 1'b0, 6'd0, '0, 1'b0},
      '{ROW_TICK, MODE_WIPE, 1'b0, 7'd0, 1'b0, 6'd0, '0, 1'b0},
      // Oversized length clamps to the full buffer.
      '{ROW_SET_LEN, MODE_WIPE, 1'b0, 7'd127, 1'b0, 6'd0, '0, 1'b0},
      '{ROW_TICK, MODE_SCAN, 1'b1, 7'd0, 1'b0, 6'd0, '0, 1'b0},
      '{ROW_TICK, MODE_WIPE, 1'b1, 7'd0, 1'b0, 6'd0, '0, 1'b0},
      '{ROW_SET_LEN, MODE_WIPE, 1'b0, 7'd64, 1'b0, 6'd0, '0, 1'b0},
      '{ROW_TICK, MODE_SCAN, 1'b0, 7'd0, 1'b0, 6'd0, '0, 1'b0},
      '{ROW_TICK, MODE_SCAN, 1'b1, 7'd0, 1'b0, 6'd0, '0, 1'b0},
      // Two LEDs: the scanner bounces quickly and steps the palette.
      '{ROW_SET_LEN, MODE_WIPE, 1'b0, 7'd2, 1'b0, 6'd0, '0, 1'b0},
      '{ROW_TICK, MODE_SCAN, 1'b1, 7'd0, 1'b0, 6'd0, '0, 1'b0},
      '{ROW_TICK, MODE_SCAN, 1'b1, 7'd0, 1'b0, 6'd0, '0, 1'b0},
      '{ROW_TICK, MODE_SCAN, 1'b1, 7'd0, 1'b0, 6'd0, '0, 1'b0},
      '{ROW_TICK, MODE_WIPE, 1'b1, 7'd0, 1'b0, 6'd0, '0, 1'b0}
   };

   led_strip_scanner_wipe_animator uut (
      .clock                (clock),
      .reset                (reset),
      .csr_write_en         (csr_write_en),
      .csr_write_data       (csr_write_data),
      .push                 (push),
      .full                 (full),
      .req_scanner_mode     (req_scanner_mode),
      .req_refresh_accepted (req_refresh_accepted),
      .empty                (empty),
      .pop                  (pop),
      .rsp_led_index        (rsp_led_index),
      .rsp_red_level        (rsp_red_level),
      .rsp_green_level      (rsp_green_level),
      .rsp_blue_level       (rsp_blue_level),
      .rsp_last_of_tick     (rsp_last_of_tick)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Returns the current palette entry and moves the shared step on; the two
   // unused step codes are treated as the first entry.
   function automatic rgb_type take_palette_color();
      palette_step_type s;
      s = pal_step;
      if (s > PaletteLast) s = PaletteFirst;
      pal_step = (s == PaletteLast) ? PaletteFirst : palette_step_type'(s + 3'd1);
      return PALETTE[s];
   endfunction

   // Applies one frame tick to the shadow state. When record is set, every pixel
   // write the tick causes is queued as an expected transaction.
   function automatic void predict_frame(input logic scan, input logic refresh,
                                         input bit record);
      int unsigned len;
      int unsigned pos;
      int unsigned span;
      int unsigned mirror;
      int unsigned idx;
      bit          has_mirror;
      rgb_type     c;
      len = strip_len;
      if (len == 0) len = 1;
      if (len > LED_SLOTS) len = LED_SLOTS;
      if (scan) begin
         pos = scan_pos;
         span = 2 * (len - 1);
         // The mirror LED only exists while the position has not passed 2*(len-1).
         has_mirror = (pos <= span);
         mirror = has_mirror ? span - pos : 0;
         for (int unsigned i = 0; i < len; i++) begin
            if (i == pos || (has_mirror && i == mirror)) begin
               c = scan_rgb;
            end else begin
               c = (shadow_pixels[i] >> 1) & HalfMask;
            end
            shadow_pixels[i] = c;
            if (record) writes_due.push_back({6'(i), c, i + 1 == len});
         end
         if (refresh) begin
            pos = scan_rev ? ((pos - 1) & 32'h7F) : ((pos + 1) & 32'h7F);
            if (pos >= len) begin
               scan_rev = 1'b1;
            end else if (pos == 0) begin
               scan_rev = 1'b0;
               scan_rgb = take_palette_color();
            end
            scan_pos = 7'(pos);
         end
      end else begin
         // The wipe moves on even when the refresh was refused.
         idx = wipe_pos;
         shadow_pixels[idx] = wipe_rgb;
         if (record) writes_due.push_back({6'(idx), wipe_rgb, 1'b1});
         idx++;
         if (idx >= len) begin
            idx = 0;
            wipe_rgb = take_palette_color();
         end
         wipe_pos = 6'(idx);
      end
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // Offers one tick, holding push until the transaction is taken, then predicts it.
   task automatic send_tick(input logic scan, input logic refresh, input bit record);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push                 <= 1'b1;
      req_scanner_mode     <= scan;
      req_refresh_accepted <= refresh;
      do @(posedge clock); while (full);
      predict_frame(scan, refresh, record);
   endtask

   // Lets every outstanding pixel write drain, then pauses for the settle wait.
   task automatic drain_writes();
      push <= 1'b0;
      while (writes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   // The strip length register may only change while the block is idle.
   task automatic set_strip_length(input logic [LenWidth-1:0] value);
      drain_writes();
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      strip_len = value;
      csr_write_en <= 1'b0;
   endtask

   // Result side: every popped pixel write is matched against the oldest expected
   // one; pop is randomly held low to stall the output register.
   always @(posedge clock) begin
      led_write_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (writes_due.size() == 0) begin
               $error("unexpected pixel write to LED %0d", rsp_led_index);
               fail_count++;
            end else begin
               want = writes_due.pop_front();
               check_field("led_index", want.led, rsp_led_index);
               check_field("red_level", want.red, rsp_red_level);
               check_field("green_level", want.green, rsp_green_level);
               check_field("blue_level", want.blue, rsp_blue_level);
               check_field("last_of_tick", want.last, rsp_last_of_tick);
            end
         end
         pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: a long stretch without any transaction on either side means a hang.
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      logic [LenWidth-1:0] seg_len;
      foreach (shadow_pixels[i]) shadow_pixels[i] = '0;
      strip_len = LenReset;
      scan_pos  = '0;
      scan_rev  = 1'b0;
      scan_rgb  = ScanColorReset;
      wipe_pos  = '0;
      wipe_rgb  = WipeColorReset;
      pal_step  = PaletteFirst;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part, under the first idling mix.
      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_SET_LEN) begin
            set_strip_length(directed_rows[r].len_value);
         end else begin
            send_tick(directed_rows[r].scan, directed_rows[r].refresh,
                      !directed_rows[r].typed);
            if (directed_rows[r].typed) begin
               writes_due.push_back({directed_rows[r].typed_led, directed_rows[r].typed_rgb,
                                     directed_rows[r].typed_last});
            end
         end
      end

      // Random part: sender lightly idle, then receiver lightly idle, then no idling.
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         drain_writes();
         send_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 60 : 0;
         recv_idle_pct = (ph == 0) ? 60 : (ph == 1) ? 10 : 0;
         for (int s = 0; s < SEGMENTS; s++) begin
            // Mostly short strips keep the run fast; the extremes turn up now and then.
            case ($urandom_range(9))
               0:       seg_len = 7'd0;
               1:       seg_len = 7'd127;
               2:       seg_len = 7'd64;
               3:       seg_len = 7'd1;
               4:       seg_len = 7'($urandom_range(126, 65));
               default: seg_len = 7'($urandom_range(12, 2));
            endcase
            set_strip_length(seg_len);
            for (int t = 0; t < SEGMENT_TICKS; t++) begin
               send_tick(1'($urandom_range(1)), $urandom_range(3) != 0, 1'b1);
            end
         end
      end

      // Wait for the tail, then give stray writes a chance to show up.
      drain_writes();
      repeat (4 * SETTLE_WAIT) @(posedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
